/* rtl/extended_euclid_mod_inverse_macros.svh */
// Assertion macros shared by the extended Euclid modular inverse RTL.
`ifndef EXTENDED_EUCLID_MOD_INVERSE_MACROS_SVH
`define EXTENDED_EUCLID_MOD_INVERSE_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define EEMI_ASSERT_IMPL(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EEMI_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EEMI_ASSERT_IMPL(name, clk_s, rst_s, ante, cons, msg)

`define EEMI_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg)

`endif

`endif

/* rtl/eemi_pkg.sv */
// Package with the microcode format, control codes and program of the inverse block.
`timescale 1ns / 1ps
`default_nettype none

package eemi_pkg;

  localparam int PC_W = 4;

  typedef logic [PC_W-1:0] upc_t;
  typedef logic [3:0]      uop_t;
  typedef logic [3:0]      ucond_t;

  // Datapath operations.
  localparam uop_t OP_NOP       = 4'd0;
  localparam uop_t OP_LOAD      = 4'd1;
  localparam uop_t OP_DIV_GO    = 4'd2;
  localparam uop_t OP_FWD_STEP  = 4'd3;
  localparam uop_t OP_RD_DEC    = 4'd4;
  localparam uop_t OP_MUL_GO    = 4'd5;
  localparam uop_t OP_BWD_STEP  = 4'd6;
  localparam uop_t OP_INV_LOAD  = 4'd7;
  localparam uop_t OP_INV_ADD_M = 4'd8;
  localparam uop_t OP_INV_SUB_M = 4'd9;
  localparam uop_t OP_EMIT      = 4'd10;

  // Jump conditions.
  localparam ucond_t C_NEVER       = 4'd0;
  localparam ucond_t C_ALWAYS      = 4'd1;
  localparam ucond_t C_NO_START    = 4'd2;
  localparam ucond_t C_FWD_DONE    = 4'd3;
  localparam ucond_t C_DIV_BUSY    = 4'd4;
  localparam ucond_t C_N_ZERO      = 4'd5;
  localparam ucond_t C_MUL_BUSY    = 4'd6;
  localparam ucond_t C_NOT_OK      = 4'd7;
  localparam ucond_t C_INV_NONNEG  = 4'd8;
  localparam ucond_t C_INV_BELOW_M = 4'd9;
  localparam ucond_t C_OUT_BUSY    = 4'd10;

  // Program addresses.
  localparam upc_t S_IDLE  = 4'd0;
  localparam upc_t S_FTEST = 4'd1;
  localparam upc_t S_DGO   = 4'd2;
  localparam upc_t S_DWAIT = 4'd3;
  localparam upc_t S_FUPD  = 4'd4;
  localparam upc_t S_BTEST = 4'd5;
  localparam upc_t S_BREAD = 4'd6;
  localparam upc_t S_MGO   = 4'd7;
  localparam upc_t S_MWAIT = 4'd8;
  localparam upc_t S_BUPD  = 4'd9;
  localparam upc_t S_INVLD = 4'd10;
  localparam upc_t S_NEGT  = 4'd11;
  localparam upc_t S_ADDM  = 4'd12;
  localparam upc_t S_GEM   = 4'd13;
  localparam upc_t S_SUBM  = 4'd14;
  localparam upc_t S_EMIT  = 4'd15;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    upc_t   target;
  } uword_t;

  typedef struct packed {
    uop_t op;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic fwd_done;
    logic div_busy;
    logic n_zero;
    logic mul_busy;
    logic not_ok;
    logic inv_neg;
    logic inv_ge_m;
    logic out_busy;
  } stat_t;

  // The control store. A taken condition jumps to target, otherwise the
  // step counter advances; from the last step it wraps to the idle step.
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    case (pc)
      S_IDLE:  w = '{OP_LOAD,      C_NO_START,    S_IDLE};
      S_FTEST: w = '{OP_NOP,       C_FWD_DONE,    S_BTEST};
      S_DGO:   w = '{OP_DIV_GO,    C_NEVER,       S_IDLE};
      S_DWAIT: w = '{OP_NOP,       C_DIV_BUSY,    S_DWAIT};
      S_FUPD:  w = '{OP_FWD_STEP,  C_ALWAYS,      S_FTEST};
      S_BTEST: w = '{OP_NOP,       C_N_ZERO,      S_INVLD};
      S_BREAD: w = '{OP_RD_DEC,    C_NEVER,       S_IDLE};
      S_MGO:   w = '{OP_MUL_GO,    C_NEVER,       S_IDLE};
      S_MWAIT: w = '{OP_NOP,       C_MUL_BUSY,    S_MWAIT};
      S_BUPD:  w = '{OP_BWD_STEP,  C_ALWAYS,      S_BTEST};
      S_INVLD: w = '{OP_INV_LOAD,  C_NOT_OK,      S_EMIT};
      S_NEGT:  w = '{OP_NOP,       C_INV_NONNEG,  S_GEM};
      S_ADDM:  w = '{OP_INV_ADD_M, C_ALWAYS,      S_NEGT};
      S_GEM:   w = '{OP_NOP,       C_INV_BELOW_M, S_EMIT};
      S_SUBM:  w = '{OP_INV_SUB_M, C_ALWAYS,      S_GEM};
      S_EMIT:  w = '{OP_EMIT,      C_OUT_BUSY,    S_EMIT};
      default: w = '{OP_NOP,       C_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/eemi_if.sv */
// Valid/ready channel interfaces for the element input and the result output.
`timescale 1ns / 1ps
`default_nettype none

interface eemi_in_if #(parameter int WIDTH = 32) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink (input valid, input element, output ready);
endinterface

interface eemi_out_if #(parameter int WIDTH = 32) ();
  logic                    valid;
  logic                    ready;
  logic [WIDTH-1:0]        gcd_value;
  logic signed [WIDTH:0]   coef_s;
  logic signed [WIDTH:0]   coef_t;
  logic [WIDTH-1:0]        inverse;
  logic                    has_inverse;

  modport source (output valid, output gcd_value, output coef_s, output coef_t,
                  output inverse, output has_inverse, input ready);
  modport sink (input valid, input gcd_value, input coef_s, input coef_t,
                input inverse, input has_inverse, output ready);
endinterface

`default_nettype wire

/* rtl/eemi_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module eemi_div #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] num,
  input  wire logic [WIDTH-1:0] den,
  output logic                  busy,
  output logic [WIDTH-1:0]      quo,
  output logic [WIDTH-1:0]      rem
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] den_r;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  assign busy  = (cnt != '0);
  assign trial = {rem, quo[WIDTH-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(WIDTH);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  // The numerator shifts out of quo while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      if (!diff[WIDTH]) begin
        rem <= diff[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/eemi_mul.sv */
// Shift-and-add multiplier, modulo 2^(WIDTH+1), that stops once the multiplier is spent.
`timescale 1ns / 1ps
`default_nettype none

module eemi_mul #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH:0]   mcand,
  input  wire logic [WIDTH-1:0] mplier,
  output logic                  busy,
  output logic [WIDTH:0]        prod
);

  logic [WIDTH:0]   mc;
  logic [WIDTH-1:0] mp;

  assign busy = (mp != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mp <= '0;
    end else if (start) begin
      mp <= mplier;
    end else if (busy) begin
      mp <= mp >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc   <= mcand;
      prod <= '0;
    end else if (busy) begin
      mc <= {mc[WIDTH-1:0], 1'b0};
      if (mp[0]) begin
        prod <= prod + mc;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/eemi_dp.sv */
// Datapath: operand and coefficient registers, quotient store, arithmetic units and result register.
`timescale 1ns / 1ps
`default_nettype none

`include "extended_euclid_mod_inverse_macros.svh"

module eemi_dp
  import eemi_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctrl_t            ctrl,
  input  wire logic [WIDTH-1:0] modulus,
  output stat_t                 stat,
  eemi_in_if.sink               req,
  eemi_out_if.source            rsp
);

  localparam int QDEPTH = 2 * WIDTH + 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int NW     = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [WIDTH:0]   s;
  logic [WIDTH:0]   t;
  logic [WIDTH:0]   inv;
  logic [NW-1:0]    n;
  logic [NW-1:0]    n_dec;
  logic [WIDTH-1:0] q_rd;
  logic [WIDTH-1:0] qmem [QDEPTH];

  logic             div_busy;
  logic [WIDTH-1:0] div_quo;
  logic [WIDTH-1:0] div_rem;
  logic             mul_busy;
  logic [WIDTH:0]   mul_prod;

  logic             out_valid;
  logic             out_busy;
  logic             gcd_one;

  assign n_dec    = n - NW'(1);
  assign gcd_one  = (y == WIDTH'(1));
  assign out_busy = out_valid && !rsp.ready;

  assign req.ready = (ctrl.op == OP_LOAD);
  assign rsp.valid = out_valid;

  assign stat.start    = req.valid;
  assign stat.fwd_done = (x == '0) || (n == NW'(QDEPTH));
  assign stat.div_busy = div_busy;
  assign stat.n_zero   = (n == '0);
  assign stat.mul_busy = mul_busy;
  assign stat.not_ok   = !gcd_one || (modulus == '0);
  assign stat.inv_neg  = inv[WIDTH];
  assign stat.inv_ge_m = (inv >= {1'b0, modulus});
  assign stat.out_busy = out_busy;

  eemi_div #(.WIDTH(WIDTH)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.op == OP_DIV_GO),
    .num   (y),
    .den   (x),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  eemi_mul #(.WIDTH(WIDTH)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (ctrl.op == OP_MUL_GO),
    .mcand  (s),
    .mplier (q_rd),
    .busy   (mul_busy),
    .prod   (mul_prod)
  );

  // Quotients are recorded on the way down and replayed in reverse order.
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_FWD_STEP) begin
      qmem[n[QAW-1:0]] <= div_quo;
    end
    if (ctrl.op == OP_RD_DEC) begin
      q_rd <= qmem[n_dec[QAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else begin
      case (ctrl.op)
        OP_LOAD:     if (req.valid) n <= '0;
        OP_FWD_STEP: n <= n + NW'(1);
        OP_RD_DEC:   n <= n_dec;
        default:     n <= n;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (req.valid) begin
          x <= req.element;
          y <= modulus;
          s <= '0;
          t <= (WIDTH + 1)'(1);
        end
      end
      OP_FWD_STEP: begin
        y <= x;
        x <= div_rem;
      end
      OP_BWD_STEP: begin
        s <= t - mul_prod;
        t <= s;
      end
      OP_INV_LOAD:  inv <= s;
      OP_INV_ADD_M: inv <= inv + {1'b0, modulus};
      OP_INV_SUB_M: inv <= inv - {1'b0, modulus};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && !out_busy) begin
      rsp.gcd_value   <= y;
      rsp.coef_s      <= s;
      rsp.coef_t      <= t;
      rsp.has_inverse <= gcd_one;
      // The reduced coefficient only means something when an inverse exists.
      if (gcd_one && modulus != '0) begin
        rsp.inverse <= inv[WIDTH-1:0];
      end else begin
        rsp.inverse <= '0;
      end
    end
  end

  `EEMI_ASSERT_IMPL(a_div_nonzero, clk, rst, ctrl.op == OP_DIV_GO, x != '0, "divider started with a zero divisor")
  `EEMI_ASSERT_IMPL(a_qmem_bound, clk, rst, ctrl.op == OP_FWD_STEP, n < NW'(QDEPTH), "quotient store overrun")
  `EEMI_ASSERT_IMPL(a_qmem_under, clk, rst, ctrl.op == OP_RD_DEC, n != '0, "quotient store read below its base")
  `EEMI_ASSERT_IMPL(a_mul_idle, clk, rst, ctrl.op == OP_MUL_GO, !mul_busy && !div_busy, "multiplier started while an arithmetic unit is busy")

endmodule

`default_nettype wire

/* rtl/eemi_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module eemi_seq
  import eemi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  upc_t   pc;
  upc_t   pc_next;
  uword_t uw;
  logic   take;

  assign uw      = ucode(pc);
  assign ctrl.op = uw.op;

  always_comb begin
    case (uw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_START:    take = !stat.start;
      C_FWD_DONE:    take = stat.fwd_done;
      C_DIV_BUSY:    take = stat.div_busy;
      C_N_ZERO:      take = stat.n_zero;
      C_MUL_BUSY:    take = stat.mul_busy;
      C_NOT_OK:      take = stat.not_ok;
      C_INV_NONNEG:  take = !stat.inv_neg;
      C_INV_BELOW_M: take = !stat.inv_ge_m;
      C_OUT_BUSY:    take = stat.out_busy;
      default:       take = 1'b0;
    endcase
  end

  // The increment past the last step wraps to the idle step.
  assign pc_next = take ? uw.target : pc + upc_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/extended_euclid_mod_inverse.sv */
// Top level of the extended Euclidean modular inverse block.
`timescale 1ns / 1ps
`default_nettype none

// For each element a, the block finds g = gcd(a, m) against the modulus m held in the
// configuration register (reset value 2) together with Bezout coefficients s and t, with
// g = a*s + m*t, and gives the inverse s mod m when g is 1 and m is nonzero (zero
// otherwise). Items are processed one at a time: the forward division steps, then a
// multiplication for each quotient on the way back, then the reduction of the inverse
// into range. Each division runs the restoring divider, which yields one quotient bit per
// cycle. A finished result waits in its output register while the next element is taken
// in. Write the modulus only while no element is in flight.
module extended_euclid_mod_inverse
  import eemi_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [WIDTH-1:0] cfg_data,
  eemi_in_if.sink               req,
  eemi_out_if.source            rsp
);

  logic [WIDTH-1:0] modulus;
  ctrl_t            ctrl;
  stat_t            stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(2);
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  eemi_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  eemi_dp #(.WIDTH(WIDTH)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .modulus (modulus),
    .stat    (stat),
    .req     (req),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire
